[rtl/assert_macros.svh]
// Assertion macros used by the checker file sha1md_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/sha1md_pkg.sv]
// Shared types and constants of the SHA-1 digest engine.
package sha1md_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] hash_t;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned NumWords  = 5;

  // Initial chaining value, word 0 in the lowest slot.
  localparam hash_t HashInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PadMarker = 8'h80;

  // Command queued between the front and the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } cmd_t;

  // Requests from the block sequencer to the round engine.
  typedef struct packed {
    logic launch;
    logic reinit;
  } rnd_ctrl_t;

  // Round engine status.
  typedef struct packed {
    logic busy;
  } rnd_stat_t;

endpackage

[rtl/sha1md_if.sv]
// Stream interfaces for message beats and digest beats.
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

[rtl/sha1md_front.sv]
// Front end: accepts message beats, drops empty ones, queues commands.
module sha1md_front (
  sha1md_in_if.sink    in_ch,
  input  logic         q_full_i,
  output logic         push_o,
  output sha1md_pkg::cmd_t push_cmd_o
);

  logic take;

  assign in_ch.ready = !q_full_i;
  assign take        = in_ch.valid && !q_full_i;

  // Drop beats that carry neither a byte nor an end mark.
  assign push_o = take && (in_ch.byte_present || in_ch.end_of_message);

  assign push_cmd_o.data_byte = in_ch.data_byte;
  assign push_cmd_o.has_byte  = in_ch.byte_present;
  assign push_cmd_o.last      = in_ch.end_of_message;

endmodule

[rtl/sha1md_fifo.sv]
// Command queue between the front end and the block sequencer.
module sha1md_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sha1md_pkg::cmd_t push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output sha1md_pkg::cmd_t pop_cmd_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  sha1md_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o    = (cnt_q == CW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/sha1md_rounds.sv]
// Round engine: one SHA-1 round per cycle, holds the chaining value.
module sha1md_rounds (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1md_pkg::rnd_ctrl_t ctrl_i,
  input  logic [sha1md_pkg::BlockBits-1:0] block_i,
  output sha1md_pkg::rnd_stat_t stat_o,
  output sha1md_pkg::hash_t     hash_o
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_RUN  = 2'd1;
  localparam logic [1:0] R_ADD  = 2'd2;

  localparam logic [6:0] LastRound = 7'd79;

  logic [1:0] st_q, st_d;
  logic [6:0] t_q, t_d;
  sha1md_pkg::hash_t h_q, h_d;
  sha1md_pkg::word_t a_q, b_q, c_q, d_q, e_q;
  sha1md_pkg::word_t a_d, b_d, c_d, d_d, e_d;
  sha1md_pkg::word_t win_q [16];
  sha1md_pkg::word_t win_d [16];
  sha1md_pkg::word_t f, k, sum, mix;

  assign stat_o.busy = (st_q != R_IDLE);
  assign hash_o      = h_q;

  // Round function and constant by quarter of the schedule.
  always_comb begin
    if (t_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = 32'h5A827999;
    end else if (t_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = 32'h6ED9EBA1;
    end else if (t_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = 32'hCA62C1D6;
    end
  end

  assign sum = {a_q[26:0], a_q[31:27]} + f + e_q + k + win_q[0];
  assign mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];

  always_comb begin
    st_d = st_q;
    t_d  = t_q;
    h_d  = h_q;
    a_d  = a_q;
    b_d  = b_q;
    c_d  = c_q;
    d_d  = d_q;
    e_d  = e_q;
    for (int i = 0; i < 16; i++) begin
      win_d[i] = win_q[i];
    end
    unique case (st_q)
      R_IDLE: begin
        if (ctrl_i.reinit) begin
          h_d = sha1md_pkg::HashInit;
        end else if (ctrl_i.launch) begin
          for (int i = 0; i < 16; i++) begin
            win_d[i] = block_i[sha1md_pkg::BlockBits-1-32*i -: 32];
          end
          a_d  = h_q[0];
          b_d  = h_q[1];
          c_d  = h_q[2];
          d_d  = h_q[3];
          e_d  = h_q[4];
          t_d  = '0;
          st_d = R_RUN;
        end
      end
      R_RUN: begin
        a_d = sum;
        b_d = a_q;
        c_d = {b_q[1:0], b_q[31:2]};
        d_d = c_q;
        e_d = d_q;
        // Slide the schedule window and append w[t+16].
        for (int i = 0; i < 15; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[15] = {mix[30:0], mix[31]};
        t_d = t_q + 1'b1;
        if (t_q == LastRound) begin
          st_d = R_ADD;
        end
      end
      R_ADD: begin
        h_d[0] = h_q[0] + a_q;
        h_d[1] = h_q[1] + b_q;
        h_d[2] = h_q[2] + c_q;
        h_d[3] = h_q[3] + d_q;
        h_d[4] = h_q[4] + e_q;
        st_d   = R_IDLE;
      end
      default: begin
        st_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= R_IDLE;
      t_q  <= '0;
      h_q  <= sha1md_pkg::HashInit;
    end else begin
      st_q <= st_d;
      t_q  <= t_d;
      h_q  <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    e_q <= e_d;
    for (int i = 0; i < 16; i++) begin
      win_q[i] <= win_d[i];
    end
  end

endmodule

[rtl/sha1md_back.sv]
// Block sequencer: fills and pads blocks, launches rounds, emits the digest.
module sha1md_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1md_pkg::cmd_t      pop_cmd_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output sha1md_pkg::rnd_ctrl_t rnd_ctrl_o,
  output logic [sha1md_pkg::BlockBits-1:0] block_o,
  input  sha1md_pkg::rnd_stat_t rnd_stat_i,
  input  sha1md_pkg::hash_t     hash_i,
  sha1md_out_if.source          out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_ZERO = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [6:0] FillFull = 7'd64;
  localparam logic [6:0] FillLen  = 7'd56;
  localparam logic [2:0] LastIdx  = 3'(sha1md_pkg::NumWords - 1);

  logic [2:0]  st_q, st_d;
  logic [6:0]  fill_q, fill_d;
  logic [60:0] count_q, count_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  lcnt_q, lcnt_d;
  logic [2:0]  idx_q, idx_d;
  logic [sha1md_pkg::BlockBits-1:0] buf_q;
  logic        shift_en, launch, has_room;
  logic [7:0]  shift_byte;

  assign has_room = (fill_q != FillFull);
  assign launch   = !has_room && !rnd_stat_i.busy;
  assign block_o  = buf_q;

  assign out_ch.valid       = (st_q == S_OUT);
  assign out_ch.digest_word = hash_i[idx_q];
  assign out_ch.word_index  = idx_q;
  assign out_ch.last_word   = (idx_q == LastIdx);

  always_comb begin
    st_d       = st_q;
    count_d    = count_q;
    len_d      = len_q;
    lcnt_d     = lcnt_q;
    idx_d      = idx_q;
    shift_en   = 1'b0;
    shift_byte = pop_cmd_i.data_byte;
    pop_o      = 1'b0;
    rnd_ctrl_o.launch = launch;
    rnd_ctrl_o.reinit = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (!empty_i && has_room) begin
          pop_o = 1'b1;
          if (pop_cmd_i.has_byte) begin
            shift_en = 1'b1;
            count_d  = count_q + 1'b1;
          end
          if (pop_cmd_i.last) begin
            st_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (has_room) begin
          shift_en   = 1'b1;
          shift_byte = sha1md_pkg::PadMarker;
          len_d      = {count_q, 3'b000};
          lcnt_d     = '0;
          st_d       = S_ZERO;
        end
      end
      S_ZERO: begin
        // Zeros up to the length field; a full block in between goes out first.
        if (fill_q == FillLen) begin
          st_d = S_LEN;
        end else if (has_room) begin
          shift_en   = 1'b1;
          shift_byte = '0;
        end
      end
      S_LEN: begin
        shift_en   = 1'b1;
        shift_byte = len_q[63:56];
        len_d      = {len_q[55:0], 8'h00};
        lcnt_d     = lcnt_q + 1'b1;
        if (lcnt_q == 3'd7) begin
          st_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if ((fill_q == '0) && !rnd_stat_i.busy) begin
          idx_d = '0;
          st_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (idx_q == LastIdx) begin
            rnd_ctrl_o.reinit = 1'b1;
            count_d = '0;
            st_d    = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    if (launch) begin
      fill_d = '0;
    end else if (shift_en) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      fill_q  <= '0;
      count_q <= '0;
      lcnt_q  <= '0;
      idx_q   <= '0;
    end else begin
      st_q    <= st_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      lcnt_q  <= lcnt_d;
      idx_q   <= idx_d;
    end
  end

  // Block bytes enter at the bottom; byte 0 ends up in the top octet.
  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (shift_en) begin
      buf_q <= {buf_q[sha1md_pkg::BlockBits-9:0], shift_byte};
    end
  end

endmodule

[rtl/sha1_message_digest.sv]
// Top level of the SHA-1 message digest engine.
//
//   port     dir  beat carries
//   in_ch    in   data_byte[7:0], byte_present, end_of_message
//   out_ch   out  digest_word[31:0], word_index[2:0], last_word
//
// In its idle state the sequencer pops a queued beat if the buffer has room;
// a beat with no byte and no end mark is dropped at the front. Each 64-byte
// block goes through the round engine (load, 80 rounds, chaining add),
// overlapped with filling the next block, so the one-round-per-cycle engine
// paces a long message. At end of message the padding goes in one byte a
// cycle while the buffer has room, followed by one or two compressions and
// five output beats. Reset is asynchronous and needs no clearing pass; a
// stalled out_ch holds the word on show while in_ch fills the queue.
module sha1_message_digest #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha1md_in_if.sink    in_ch,
  sha1md_out_if.source out_ch
);

  logic                  push, q_full, pop, q_empty;
  sha1md_pkg::cmd_t      push_cmd, pop_cmd;
  sha1md_pkg::rnd_ctrl_t rnd_ctrl;
  sha1md_pkg::rnd_stat_t rnd_stat;
  sha1md_pkg::hash_t     hash;
  logic [sha1md_pkg::BlockBits-1:0] block;

  sha1md_front u_front (
    .in_ch      (in_ch),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  sha1md_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty)
  );

  sha1md_rounds u_rounds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rnd_ctrl),
    .block_i (block),
    .stat_o  (rnd_stat),
    .hash_o  (hash)
  );

  sha1md_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_cmd_i  (pop_cmd),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .rnd_ctrl_o (rnd_ctrl),
    .block_o    (block),
    .rnd_stat_i (rnd_stat),
    .hash_i     (hash),
    .out_ch     (out_ch)
  );

endmodule

[rtl/sha1md_checker.sv]
// Port-level checks on the digest output of the SHA-1 engine.
`include "assert_macros.svh"

module sha1md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] digest_word_i,
  input logic [2:0]  word_index_i,
  input logic        last_word_i
);

  // A stalled word holds.
  `ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(digest_word_i) && $stable(word_index_i))
  // The digest opens with word zero.
  `ASSERT_IMPL(a_first_word, $rose(out_valid_i), word_index_i == 3'd0)
  // Words follow back to back in order.
  `ASSERT_NEXT(a_word_seq, out_valid_i && out_ready_i && !last_word_i, out_valid_i && (word_index_i == $past(word_index_i) + 3'd1))
  // The last word closes the digest.
  `ASSERT_NEXT(a_last_ends, out_valid_i && out_ready_i && last_word_i, !out_valid_i)

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .digest_word_i (out_ch.digest_word),
  .word_index_i  (out_ch.word_index),
  .last_word_i   (out_ch.last_word)
);
